### src/cmdc_pkg.sv
`default_nettype none

package cmdc_pkg;

	// direction and configuration widths
	localparam int COMP_BITS    = 16;
	localparam int MAX_FACE_RES = 1024;
	localparam int NW           = 11;
	localparam int CW           = 10;
	localparam int MAG_W        = COMP_BITS;
	localparam int TW           = COMP_BITS + 1;
	localparam int DIVISOR_W    = COMP_BITS + 1;
	localparam int PROD_W       = TW + NW;
	localparam int QW           = NW;
	localparam int NN_W         = 2 * NW - 1;
	localparam int IDX_W        = 23;

	// apb register map
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;
	localparam logic [0:0] REG_FACE_RES = 1'b0;
	localparam logic [NW-1:0] FACE_RES_RESET = NW'(64);

	// face codes
	typedef logic [2:0] face_t;
	localparam face_t FACE_POS_X = 3'd0;
	localparam face_t FACE_NEG_X = 3'd1;
	localparam face_t FACE_POS_Y = 3'd2;
	localparam face_t FACE_NEG_Y = 3'd3;
	localparam face_t FACE_POS_Z = 3'd4;
	localparam face_t FACE_NEG_Z = 3'd5;

	// data that rides alongside the divider
	typedef struct packed {
		face_t           face;
		logic            zero;
		logic [NW-1:0]   n;
		logic [NN_W-1:0] nn;
	} side_t;

endpackage

`default_nettype wire

### src/cmdc_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor
module cmdc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [cmdc_pkg::PROD_W-1:0]    dividend_row,
	input  wire logic [cmdc_pkg::PROD_W-1:0]    dividend_col,
	input  wire logic [cmdc_pkg::DIVISOR_W-1:0] divisor,
	input  wire cmdc_pkg::side_t                side_in,
	output logic                                out_valid,
	output logic [cmdc_pkg::QW-1:0]             quo_row,
	output logic [cmdc_pkg::QW-1:0]             quo_col,
	output cmdc_pkg::side_t                     side_out
);
	import cmdc_pkg::*;

	// registered outputs of each stage
	logic                  vld_s   [QW];
	logic [PROD_W-1:0]     rem_r_s [QW];
	logic [PROD_W-1:0]     rem_c_s [QW];
	logic [QW-1:0]         quo_r_s [QW];
	logic [QW-1:0]         quo_c_s [QW];
	logic [DIVISOR_W-1:0]  div_s   [QW];
	side_t                 side_s  [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int K = QW - 1 - g;
		logic                 vld_in;
		logic [PROD_W-1:0]    rem_r_in;
		logic [PROD_W-1:0]    rem_c_in;
		logic [QW-1:0]        quo_r_in;
		logic [QW-1:0]        quo_c_in;
		logic [DIVISOR_W-1:0] div_in;
		side_t                side_g;
		logic [PROD_W-1:0]    sh;
		logic                 ge_r;
		logic                 ge_c;

		// first stage takes the ports, the others the previous stage
		if (g == 0) begin : g_first
			assign vld_in   = in_valid;
			assign rem_r_in = dividend_row;
			assign rem_c_in = dividend_col;
			assign quo_r_in = '0;
			assign quo_c_in = '0;
			assign div_in   = divisor;
			assign side_g   = side_in;
		end else begin : g_next
			assign vld_in   = vld_s[g-1];
			assign rem_r_in = rem_r_s[g-1];
			assign rem_c_in = rem_c_s[g-1];
			assign quo_r_in = quo_r_s[g-1];
			assign quo_c_in = quo_c_s[g-1];
			assign div_in   = div_s[g-1];
			assign side_g   = side_s[g-1];
		end

		// trial subtract of the divisor shifted to this bit
		always_comb begin
			sh   = PROD_W'(div_in) << K;
			ge_r = (rem_r_in >= sh);
			ge_c = (rem_c_in >= sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_r_s[g] <= ge_r ? (rem_r_in - sh) : rem_r_in;
			rem_c_s[g] <= ge_c ? (rem_c_in - sh) : rem_c_in;
			quo_r_s[g] <= {quo_r_in[QW-2:0], ge_r};
			quo_c_s[g] <= {quo_c_in[QW-2:0], ge_c};
			div_s[g]   <= div_in;
			side_s[g]  <= side_g;
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo_row   = quo_r_s[QW-1];
	assign quo_col   = quo_c_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

`default_nettype wire

### src/cube_map_direction_to_cell_top.sv
`default_nettype none

// Cube-map face selection: a direction (dir_x, dir_y, dir_z) accepted when
// start is high and busy is low comes out as face, row, column and linear
// cell index, marked by a one-cycle done strobe.
// One direction can be accepted every cycle and busy is always low; the
// receiver must take each result in the cycle that done is high. Row and
// column are formed by the 11-stage divider, one quotient bit per stage.
// The face resolution register is sampled with each direction, so an item
// in flight keeps the resolution it entered with. A zero vector gives face 1,
// row 0, column 0, index N*N and raises zero_vector.
module cube_map_direction_to_cell_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// command channel
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [cmdc_pkg::COMP_BITS-1:0] dir_x,
	input  wire logic signed [cmdc_pkg::COMP_BITS-1:0] dir_y,
	input  wire logic signed [cmdc_pkg::COMP_BITS-1:0] dir_z,
	// result channel
	output logic                                 done,
	output logic [2:0]                           face_number,
	output logic [cmdc_pkg::CW-1:0]              cell_row,
	output logic [cmdc_pkg::CW-1:0]              cell_col,
	output logic [cmdc_pkg::IDX_W-1:0]           cell_index,
	output logic                                 zero_vector,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [cmdc_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [cmdc_pkg::DATA_W-1:0]     pwdata,
	output logic [cmdc_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);
	import cmdc_pkg::*;

	typedef logic signed [COMP_BITS:0] num_t;

	logic [NW-1:0] face_res_q;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FACE_RES) ? DATA_W'(face_res_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_res_q <= FACE_RES_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FACE_RES)) begin
			face_res_q <= pwdata[NW-1:0];
		end
	end

	assign busy = 1'b0;

	// stage 1: magnitudes, face choice, numerators
	logic [MAG_W-1:0] ax, ay, az;
	num_t             sx, sy, sz;
	face_t            face_c;
	num_t             un_c, vn_c;
	logic [MAG_W-1:0] major_c;
	logic [NW-1:0]    n_c;
	logic             in_xfer;

	assign in_xfer = start && !busy;

	always_comb begin
		ax = dir_x[COMP_BITS-1] ? (~dir_x + 1'b1) : dir_x;
		ay = dir_y[COMP_BITS-1] ? (~dir_y + 1'b1) : dir_y;
		az = dir_z[COMP_BITS-1] ? (~dir_z + 1'b1) : dir_z;
		sx = {dir_x[COMP_BITS-1], dir_x};
		sy = {dir_y[COMP_BITS-1], dir_y};
		sz = {dir_z[COMP_BITS-1], dir_z};
		priority if (ax >= ay && ax >= az) begin
			major_c = ax;
			vn_c    = sy;
			if (!dir_x[COMP_BITS-1] && (dir_x != '0)) begin
				face_c = FACE_POS_X;
				un_c   = -sz;
			end else begin
				face_c = FACE_NEG_X;
				un_c   = sz;
			end
		end else if (ay >= az) begin
			major_c = ay;
			un_c    = sx;
			if (!dir_y[COMP_BITS-1]) begin
				face_c = FACE_POS_Y;
				vn_c   = -sz;
			end else begin
				face_c = FACE_NEG_Y;
				vn_c   = sz;
			end
		end else begin
			major_c = az;
			vn_c    = sy;
			if (!dir_z[COMP_BITS-1]) begin
				face_c = FACE_POS_Z;
				un_c   = sx;
			end else begin
				face_c = FACE_NEG_Z;
				un_c   = -sx;
			end
		end
		// resolution saturates to 1..MAX_FACE_RES
		priority if (face_res_q == '0) begin
			n_c = NW'(1);
		end else if (face_res_q > NW'(MAX_FACE_RES)) begin
			n_c = NW'(MAX_FACE_RES);
		end else begin
			n_c = face_res_q;
		end
	end

	logic             valid_s1;
	face_t            face_s1;
	logic             zero_s1;
	num_t             un_s1, vn_s1;
	logic [MAG_W-1:0] major_s1;
	logic [NW-1:0]    n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		face_s1  <= face_c;
		zero_s1  <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
		un_s1    <= un_c;
		vn_s1    <= vn_c;
		major_s1 <= major_c;
		n_s1     <= n_c;
	end

	// stage 2: offset numerators, divisor, n squared
	function automatic logic [TW-1:0] offset_num(input num_t num, input logic [MAG_W-1:0] major);
		logic signed [COMP_BITS+1:0] sum;
		sum = {num[COMP_BITS], num} + $signed({2'b00, major});
		return sum[COMP_BITS+1] ? '0 : sum[TW-1:0];
	endfunction

	logic [2*NW-1:0]      nn_full;
	logic                 valid_s2;
	side_t                side_s2;
	logic [TW-1:0]        t_row_s2, t_col_s2;
	logic [DIVISOR_W-1:0] divisor_s2;

	assign nn_full = n_s1 * n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.face <= face_s1;
		side_s2.zero <= zero_s1;
		side_s2.n    <= n_s1;
		side_s2.nn   <= nn_full[NN_W-1:0];
		t_row_s2     <= offset_num(un_s1, major_s1);
		t_col_s2     <= offset_num(vn_s1, major_s1);
		divisor_s2   <= {major_s1, 1'b0};
	end

	// stage 3: dividends t*n
	logic                 valid_s3;
	side_t                side_s3;
	logic [PROD_W-1:0]    dvd_row_s3, dvd_col_s3;
	logic [DIVISOR_W-1:0] divisor_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3    <= side_s2;
		dvd_row_s3 <= PROD_W'(t_row_s2) * PROD_W'(side_s2.n);
		dvd_col_s3 <= PROD_W'(t_col_s2) * PROD_W'(side_s2.n);
		divisor_s3 <= divisor_s2;
	end

	// stages 4 to 14: divide by twice the major magnitude
	logic          valid_s14;
	logic [QW-1:0] q_row_s14, q_col_s14;
	side_t         side_s14;

	cmdc_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (valid_s3),
		.dividend_row (dvd_row_s3),
		.dividend_col (dvd_col_s3),
		.divisor      (divisor_s3),
		.side_in      (side_s3),
		.out_valid    (valid_s14),
		.quo_row      (q_row_s14),
		.quo_col      (q_col_s14),
		.side_out     (side_s14)
	);

	// stage 15: clamp to n-1, force zero vector
	logic          valid_s15;
	side_t         side_s15;
	logic [CW-1:0] row_s15, col_s15;
	logic [NW-1:0] n_m1;

	assign n_m1 = side_s14.n - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s15 <= 1'b0;
		end else begin
			valid_s15 <= valid_s14;
		end
	end

	always_ff @(posedge clk) begin
		side_s15.zero <= side_s14.zero;
		side_s15.n    <= side_s14.n;
		side_s15.nn   <= side_s14.nn;
		if (side_s14.zero) begin
			side_s15.face <= FACE_NEG_X;
			row_s15       <= '0;
			col_s15       <= '0;
		end else begin
			side_s15.face <= side_s14.face;
			row_s15 <= (q_row_s14 >= side_s14.n) ? n_m1[CW-1:0] : q_row_s14[CW-1:0];
			col_s15 <= (q_col_s14 >= side_s14.n) ? n_m1[CW-1:0] : q_col_s14[CW-1:0];
		end
	end

	// stage 16: partial products of the linear index
	logic                valid_s16;
	face_t               face_s16;
	logic                zero_s16;
	logic [CW-1:0]       row_s16, col_s16;
	logic [NN_W+2:0]     face_nn_s16;
	logic [CW+NW-1:0]    row_n_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s16 <= 1'b0;
		end else begin
			valid_s16 <= valid_s15;
		end
	end

	always_ff @(posedge clk) begin
		face_s16    <= side_s15.face;
		zero_s16    <= side_s15.zero;
		row_s16     <= row_s15;
		col_s16     <= col_s15;
		face_nn_s16 <= (NN_W+3)'(side_s15.face) * (NN_W+3)'(side_s15.nn);
		row_n_s16   <= (CW+NW)'(row_s15) * (CW+NW)'(side_s15.n);
	end

	// stage 17: index sum and result registers
	logic             valid_s17;
	face_t            face_s17;
	logic             zero_s17;
	logic [CW-1:0]    row_s17, col_s17;
	logic [IDX_W-1:0] index_s17;
	logic [NN_W+3:0]  index_sum;

	assign index_sum = (NN_W+4)'(face_nn_s16) + (NN_W+4)'(row_n_s16) + (NN_W+4)'(col_s16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s17 <= 1'b0;
		end else begin
			valid_s17 <= valid_s16;
		end
	end

	always_ff @(posedge clk) begin
		face_s17  <= face_s16;
		zero_s17  <= zero_s16;
		row_s17   <= row_s16;
		col_s17   <= col_s16;
		index_s17 <= index_sum[IDX_W-1:0];
	end

	assign done        = valid_s17;
	assign face_number = face_s17;
	assign cell_row    = row_s17;
	assign cell_col    = col_s17;
	assign cell_index  = index_s17;
	assign zero_vector = zero_s17;

	// checks
	a_valid_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s16 |=> done)
		else $error("result transfer lost at the last stage");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_vector) |-> (face_number == FACE_NEG_X && cell_row == '0 && cell_col == '0))
		else $error("zero vector result not forced");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (face_number <= FACE_NEG_Z))
		else $error("face code out of range");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s15 |-> (NW'(row_s15) < side_s15.n && NW'(col_s15) < side_s15.n))
		else $error("cell coordinate not clamped to face size");

endmodule

`default_nettype wire
